// ===== rtl/core/fatde_pkg.sv =====
`default_nettype none
package fatde_pkg;

  localparam int MAX_NAME_PARTS = 4;
  localparam int CHARS_PER_PART = 13;
  localparam int NAME_DEPTH     = MAX_NAME_PARTS * CHARS_PER_PART + 1;
  localparam int NAME_AW        = $clog2(NAME_DEPTH);
  localparam int ENTRY_BYTES    = 32;
  localparam int POS_W          = $clog2(ENTRY_BYTES);
  localparam int SHORT_NAME_LEN = 11;
  localparam int SHORT_BASE_LEN = 8;
  localparam int WBUF_LEN       = CHARS_PER_PART + 1;
  localparam int WCNT_W         = $clog2(WBUF_LEN + 1);
  localparam int SEQ_W          = 6;

  localparam logic [7:0] FIRST_FREE    = 8'h00;
  localparam logic [7:0] FIRST_KANJI   = 8'h05;
  localparam logic [7:0] FIRST_DELETED = 8'hE5;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] ATTR_LFN      = 8'h0F;
  localparam int         ATTR_DIR_BIT  = 4;
  localparam int         SEQ_LAST_BIT  = 6;
  localparam int         ATTR_POS      = 11;
  localparam int         LFN_CKS_POS   = 13;

  localparam logic [POS_W-1:0] LFN_OFF [CHARS_PER_PART] =
    '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30};

  typedef logic [ENTRY_BYTES-1:0][7:0] entry_t;
  typedef logic [NAME_AW-1:0] naddr_t;

  typedef struct packed {
    entry_t     bytes;
    logic [7:0] sum;
    logic       done;
  } cap_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_WR,
    S_ISSUE,
    S_RD,
    S_OUT
  } fsm_t;

endpackage
`default_nettype wire

// ===== rtl/core/fatde_capture.sv =====
`default_nettype none
module fatde_capture (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       entry_byte,
  output fatde_pkg::cap_t  cap
);
  import fatde_pkg::*;

  entry_t           ent_r;
  logic [POS_W-1:0] pos_r;
  logic [7:0]       sum_r;
  logic [7:0]       sum_nxt;

  // rotate-add checksum over the 11 short name bytes, built as they arrive
  assign sum_nxt = ((pos_r == '0) ? 8'd0 : {sum_r[0], sum_r[7:1]}) + entry_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (accept) begin
      pos_r <= pos_r + 1'b1;
      if (pos_r < POS_W'(SHORT_NAME_LEN)) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r[pos_r] <= entry_byte;
    end
  end

  assign cap.bytes = ent_r;
  assign cap.sum   = sum_r;
  assign cap.done  = accept && (pos_r == POS_W'(ENTRY_BYTES - 1));

endmodule
`default_nettype wire

// ===== rtl/core/fatde_name_ram.sv =====
`default_nettype none
module fatde_name_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  fatde_pkg::naddr_t waddr,
  input  logic [7:0]        wdata,
  input  fatde_pkg::naddr_t raddr,
  output logic [7:0]        rdata
);
  import fatde_pkg::*;

  logic [7:0]            mem [NAME_DEPTH];
  logic [NAME_DEPTH-1:0] vld_r;
  logic [7:0]            rd_r;
  logic                  rv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rv_r <= vld_r[raddr];
    end
  end

  assign rdata = rv_r ? rd_r : 8'd0;

endmodule
`default_nettype wire

// ===== rtl/core/fat_directory_entry_decoder_top.sv =====
`default_nettype none
// Sequence: an entry is decoded in the cycle after its 32nd byte; a long-name entry then makes
// 13 or 14 name memory writes, a short entry up to 13 (none if the long name is used),
// then S_ISSUE starts reads and S_RD fetches one or two chars before the first word.
// Throughput: one byte per cycle within an entry; a name run alternates S_RD and S_OUT
// per word (name memory read plus one-char lookahead), input stalled while not idle.
// Reset: clears byte position, pending flag, kept checksum and name memory valid bits.
module fat_directory_entry_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_entry_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_name_char,
  output logic        out_last_char,
  output logic [7:0]  out_attributes,
  output logic [31:0] out_file_size,
  output logic [31:0] out_first_cluster,
  output logic        out_long_name_used,
  output logic        out_checksum_mismatch
);
  import fatde_pkg::*;

  cap_t   cap;
  entry_t ent;
  logic   in_acc;

  fsm_t   state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic [7:0] expck_r, expck_nxt;
  logic   used_r, used_nxt;
  logic   mism_r, mism_nxt;
  logic   islong_r, islong_nxt;
  logic [WBUF_LEN-1:0][7:0] wbuf_r, wbuf_nxt;
  naddr_t wa_r, wa_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  naddr_t k_r, k_nxt;
  logic   have_r, have_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic [7:0] nx_r, nx_nxt;
  logic   last_r, last_nxt;

  logic       ram_we;
  naddr_t     ram_raddr;
  logic [7:0] ram_rdata;

  logic [WBUF_LEN-1:0][7:0] l_lane, s_lane;
  logic [WCNT_W-1:0] sn_len, sn_tot;
  logic       sn_ext, sn_stop;
  logic [SEQ_W-1:0] seq;
  logic       skip;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ent      = cap.bytes;

  fatde_capture u_cap (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .entry_byte (in_entry_byte),
    .cap        (cap)
  );

  fatde_name_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (wa_r),
    .wdata (wbuf_r[0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin : lanes
    sn_len  = '0;
    sn_stop = 1'b0;
    for (int p = 0; p < SHORT_BASE_LEN; p++) begin
      if (!sn_stop && ent[p] != CH_SPACE) begin
        sn_len = sn_len + 1'b1;
      end else begin
        sn_stop = 1'b1;
      end
    end
    sn_ext = (ent[SHORT_BASE_LEN] != CH_SPACE);
    sn_tot = sn_len + (sn_ext ? WCNT_W'(4) : WCNT_W'(0));
    for (int p = 0; p < WBUF_LEN; p++) begin
      if (WCNT_W'(p) < sn_len) begin
        s_lane[p] = ent[p];
      end else if (sn_ext && WCNT_W'(p) == sn_len) begin
        s_lane[p] = CH_DOT;
      end else if (sn_ext && WCNT_W'(p) == sn_len + WCNT_W'(1)) begin
        s_lane[p] = ent[SHORT_BASE_LEN];
      end else if (sn_ext && WCNT_W'(p) == sn_len + WCNT_W'(2)) begin
        s_lane[p] = ent[SHORT_BASE_LEN + 1];
      end else if (sn_ext && WCNT_W'(p) == sn_len + WCNT_W'(3)) begin
        s_lane[p] = ent[SHORT_BASE_LEN + 2];
      end else begin
        s_lane[p] = 8'd0;
      end
    end
    for (int p = 0; p < CHARS_PER_PART; p++) begin
      l_lane[p] = ent[LFN_OFF[p]];
    end
    l_lane[WBUF_LEN-1] = 8'd0;
  end

  assign seq  = ent[0][SEQ_W-1:0];
  assign skip = (ent[0] == FIRST_FREE) || (ent[0] == FIRST_KANJI) ||
                (ent[0] == FIRST_DELETED) || (ent[0] == CH_DOT);

  always_comb begin : fsm
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    expck_nxt  = expck_r;
    used_nxt   = used_r;
    mism_nxt   = mism_r;
    islong_nxt = islong_r;
    wbuf_nxt   = wbuf_r;
    wa_nxt     = wa_r;
    wcnt_nxt   = wcnt_r;
    k_nxt      = k_r;
    have_nxt   = have_r;
    cur_nxt    = cur_r;
    nx_nxt     = nx_r;
    last_nxt   = last_r;
    ram_we     = 1'b0;
    ram_raddr  = k_r;
    case (state_r)
      S_IDLE: begin
        if (cap.done) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (skip) begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if ((ent[ATTR_POS] & ATTR_LFN) == ATTR_LFN) begin
          if (seq == '0 || seq > SEQ_W'(MAX_NAME_PARTS)) begin
            state_nxt = S_IDLE;
          end else begin
            wbuf_nxt   = l_lane;
            wcnt_nxt   = ent[0][SEQ_LAST_BIT] ? WCNT_W'(WBUF_LEN) : WCNT_W'(CHARS_PER_PART);
            wa_nxt     = NAME_AW'((seq - 1'b1) * NAME_AW'(CHARS_PER_PART));
            islong_nxt = 1'b1;
            pend_nxt   = 1'b1;
            expck_nxt  = ent[LFN_CKS_POS];
            state_nxt  = S_WR;
          end
        end else begin
          mism_nxt   = pend_r && (cap.sum != expck_r);
          used_nxt   = pend_r && (cap.sum == expck_r);
          pend_nxt   = 1'b0;
          islong_nxt = 1'b0;
          wbuf_nxt   = s_lane;
          wcnt_nxt   = sn_tot + 1'b1;
          wa_nxt     = '0;
          if (pend_r && (cap.sum == expck_r)) begin
            state_nxt = S_ISSUE;
          end else begin
            state_nxt = S_WR;
          end
        end
      end
      S_WR: begin
        ram_we   = 1'b1;
        wbuf_nxt = {8'd0, wbuf_r[WBUF_LEN-1:1]};
        wa_nxt   = wa_r + 1'b1;
        wcnt_nxt = wcnt_r - 1'b1;
        if (wcnt_r == WCNT_W'(1)) begin
          state_nxt = islong_r ? S_IDLE : S_ISSUE;
        end
      end
      S_ISSUE: begin
        ram_raddr = '0;
        k_nxt     = '0;
        have_nxt  = 1'b0;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (!have_r) begin
          cur_nxt = ram_rdata;
          if (ram_rdata == 8'd0 || k_r == NAME_AW'(NAME_DEPTH - 1)) begin
            last_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            ram_raddr = k_r + 1'b1;
            have_nxt  = 1'b1;
          end
        end else begin
          nx_nxt    = ram_rdata;
          last_nxt  = (ram_rdata == 8'd0);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt   = k_r + 1'b1;
            cur_nxt = nx_r;
            if (k_r + 1'b1 == NAME_AW'(NAME_DEPTH - 1)) begin
              last_nxt = 1'b1;
            end else begin
              ram_raddr = k_r + NAME_AW'(2);
              state_nxt = S_RD;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      expck_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      expck_r <= expck_nxt;
    end
  end

  always_ff @(posedge clk) begin
    used_r   <= used_nxt;
    mism_r   <= mism_nxt;
    islong_r <= islong_nxt;
    wbuf_r   <= wbuf_nxt;
    wa_r     <= wa_nxt;
    wcnt_r   <= wcnt_nxt;
    k_r      <= k_nxt;
    have_r   <= have_nxt;
    cur_r    <= cur_nxt;
    nx_r     <= nx_nxt;
    last_r   <= last_nxt;
  end

  // entry bytes hold still while the input is stalled
  assign out_valid             = (state_r == S_OUT);
  assign out_name_char         = cur_r;
  assign out_last_char         = last_r;
  assign out_attributes        = ent[ATTR_POS];
  assign out_file_size         = ent[ATTR_POS][ATTR_DIR_BIT] ? 32'hFFFF_FFFF :
                                 {ent[31], ent[30], ent[29], ent[28]};
  assign out_first_cluster     = {ent[21], ent[20], ent[27], ent[26]};
  assign out_long_name_used    = used_r;
  assign out_checksum_mismatch = mism_r;

  a_wr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> wcnt_r != '0)
    else $error("name write with empty count");

  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> wa_r < NAME_AW'(NAME_DEPTH))
    else $error("name write beyond memory");

  a_rd_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !last_r) |-> k_r < NAME_AW'(NAME_DEPTH - 1))
    else $error("lookahead past end of name memory");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_char) |=> state_r == S_IDLE)
    else $error("run did not end after last word");

endmodule
`default_nettype wire
